>>> rtl/fcc_pkg.sv
package fcc_pkg;

  // Fixed framing bytes, header size and minimum frame size.
  localparam logic [7:0] SOF_BYTE     = 8'hAA;
  localparam logic [7:0] EOF_BYTE     = 8'h55;
  localparam int         HDR_BYTES    = 4;
  localparam int         MIN_FRAME    = 6;
  // CRC-8/MAXIM: polynomial 0x31, processed LSB first as its mirror 0x8C.
  localparam logic [7:0] CRC_POLY_REF = 8'h8C;

  // Configuration register indexes.
  localparam int         CFG_IDX_W    = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_NOTIFY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_REALTIME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_STATUS   = 2'd2;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_BAD_SOF  = 3'd2,
    ST_BAD_EOF  = 3'd3,
    ST_LENGTH   = 3'd4,
    ST_CRC      = 3'd5,
    ST_TOO_LONG = 3'd6,
    ST_TYPE     = 3'd7
  } status_t;

  // Verdict of a frame, produced on the cycle its last byte is taken.
  typedef struct packed {
    logic        valid;
    logic        run;     // accepted with a nonempty payload: replay from the store
    status_t     status;
    logic [7:0]  ftype;
    logic [15:0] flen;
  } fcc_done_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REF) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> rtl/fcc_ifs.sv
interface fcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;
  modport source (output valid, rx_byte, frame_end, input ready);
  modport sink (input valid, rx_byte, frame_end, output ready);
endinterface

interface fcc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  frame_type;
  logic [15:0] payload_length;
  logic [7:0]  payload_byte;
  logic        has_byte;
  logic        run_last;
  modport source (output valid, status, frame_type, payload_length, payload_byte,
                  has_byte, run_last, input ready);
  modport sink (input valid, status, frame_type, payload_length, payload_byte,
                has_byte, run_last, output ready);
endinterface

interface fcc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] reg_index;
  logic [7:0] wr_data;
  modport source (output valid, reg_index, wr_data, input ready);
  modport sink (input valid, reg_index, wr_data, output ready);
endinterface

>>> rtl/frame_check_crc8_deframer.sv
// Frame checker and deframer for byte-serial frames of the form
// SOF 0xAA, type, 16-bit little-endian length L, L payload bytes, CRC-8/MAXIM
// over SOF through payload, EOF 0x55.
// in_ch takes one raw byte per item; frame_end marks the last byte of a frame.
// Items without frame_end produce nothing. The last byte produces either one
// status item (rejected frame, or accepted frame with L = 0, has_byte low) or,
// for an accepted frame, one item per payload byte with run_last on the final one.
// cfg_ch writes the three accepted type codes (indexes 0, 1, 2; reset 1, 2, 3)
// and is always ready; write it only while the block is idle.
// Throughput is one byte per cycle while in_ch is ready. A status item appears in
// the cycle after the last byte; a replay sets its engine active, then reads one
// payload byte per cycle while out_ch is ready, a rate the single read port sets.
// While a replay runs, the next frame's bytes keep flowing in, except that any
// byte past the header waits until the replay has read the entry at its offset,
// and the next frame's last byte waits until the replay is finished.
// A stalled out_ch holds its item in the output register; input then backs up
// only when a result or a replay read has nowhere to go.
// Reset is synchronous and active low; it clears frame state, reloads type codes.
// The payload memory needs no clearing pass: every byte replayed was written
// earlier in the same frame.
module frame_check_crc8_deframer import fcc_pkg::*; #(
  parameter int MAX_FRAME = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  fcc_in_if.sink    in_ch,
  fcc_out_if.source out_ch,
  fcc_cfg_if.sink   cfg_ch
);

  // Payload bytes that fit in a frame of MAX_FRAME bytes; at least one entry
  // is kept so the memory is never empty.
  localparam int STORE_USED  = MAX_FRAME - MIN_FRAME;
  localparam int STORE_DEPTH = (STORE_USED > 0) ? STORE_USED : 1;
  localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int PW          = $clog2(MAX_FRAME);

  logic          in_acc;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_q;
  logic          pay_phase;
  logic [PW-1:0] pay_k;
  logic          rp_active;
  logic [AW-1:0] rp_ptr;
  fcc_done_t     done;
  logic          wr_hazard;
  logic          end_blocked;

  // A payload byte of the next frame may only land in an entry that the
  // running replay has already read.
  assign wr_hazard   = rp_active && pay_phase && (pay_k >= PW'(rp_ptr));
  // A last byte needs a free output register and a free replay engine.
  assign end_blocked = in_ch.frame_end && (rp_active || (out_ch.valid && !out_ch.ready));

  assign in_ch.ready = !wr_hazard && !end_blocked;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  fcc_frame #(
    .MAX_FRAME (MAX_FRAME),
    .PW        (PW),
    .AW        (AW)
  ) u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .rx_byte   (in_ch.rx_byte),
    .frame_end (in_ch.frame_end),
    .cfg_we    (cfg_ch.valid),
    .cfg_idx   (cfg_ch.reg_index),
    .cfg_data  (cfg_ch.wr_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .pay_phase (pay_phase),
    .pay_k     (pay_k),
    .done      (done)
  );

  fcc_store #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_q    (rd_q)
  );

  fcc_replay #(
    .AW (AW)
  ) u_replay (
    .clk        (clk),
    .rst_n      (rst_n),
    .done       (done),
    .rd_q       (rd_q),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rp_active  (rp_active),
    .rp_ptr     (rp_ptr),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.status),
    .out_type   (out_ch.frame_type),
    .out_len    (out_ch.payload_length),
    .out_byte   (out_ch.payload_byte),
    .out_has    (out_ch.has_byte),
    .out_last   (out_ch.run_last)
  );

endmodule

>>> rtl/fcc_store.sv
module fcc_store #(
  parameter int DEPTH = 26,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_q
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data is held while the output stage is stalled.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  assign rd_q = rd_q_r;

endmodule

>>> rtl/fcc_frame.sv
module fcc_frame import fcc_pkg::*; #(
  parameter int MAX_FRAME = 32,
  parameter int PW        = 5,
  parameter int AW        = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 acc,
  input  logic [7:0]           rx_byte,
  input  logic                 frame_end,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [7:0]           cfg_data,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output logic [7:0]           wr_data,
  output logic                 pay_phase,
  output logic [PW-1:0]        pay_k,
  output fcc_done_t            done
);

  localparam logic [PW:0]  MAX_CNT    = (PW+1)'(MAX_FRAME);
  localparam logic [PW:0]  STORE_USED = (PW+1)'(MAX_FRAME - MIN_FRAME);
  localparam logic [PW:0]  MIN_CNT    = (PW+1)'(MIN_FRAME);
  localparam logic [PW-1:0] HDR      = PW'(HDR_BYTES);

  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    crc_r, crc_nxt;
  logic [7:0]    type_r, type_nxt;
  logic [15:0]   len_r, len_nxt;
  logic [7:0]    rcrc_r, rcrc_nxt;
  logic          sok_r, sok_nxt;
  logic          ovf_r, ovf_nxt;
  logic [7:0]    cfg_notify_r, cfg_realtime_r, cfg_status_r;

  assign pay_k     = pos_r - HDR;
  assign pay_phase = !ovf_r && (pos_r >= HDR);
  assign wr_data   = rx_byte;

  always_comb begin
    logic [PW-1:0] k;
    logic [7:0]    u_crc, u_type, u_rcrc;
    logic [15:0]   u_len;
    logic          u_sok;
    logic [PW:0]   cnt;
    status_t       st;

    k       = pos_r - HDR;
    u_crc   = crc_r;
    u_type  = type_r;
    u_len   = len_r;
    u_rcrc  = rcrc_r;
    u_sok   = sok_r;
    cnt     = {1'b0, pos_r} + (PW+1)'(1);
    st      = ST_OK;
    wr_en   = 1'b0;
    wr_addr = AW'(k);
    pos_nxt = pos_r;
    ovf_nxt = ovf_r;
    done    = '0;

    if (acc && !ovf_r) begin
      case (pos_r)
        PW'(0): begin
          u_type = 8'd0;
          u_len  = 16'd0;
          u_rcrc = 8'd0;
          u_sok  = (rx_byte == SOF_BYTE);
          u_crc  = crc8_update(8'd0, rx_byte);
        end
        PW'(1): begin
          u_type = rx_byte;
          u_crc  = crc8_update(crc_r, rx_byte);
        end
        PW'(2): begin
          u_len = {len_r[15:8], rx_byte};
          u_crc = crc8_update(crc_r, rx_byte);
        end
        PW'(3): begin
          u_len = {rx_byte, len_r[7:0]};
          u_crc = crc8_update(crc_r, rx_byte);
        end
        default: begin
          if (16'(k) < len_r) begin
            u_crc = crc8_update(crc_r, rx_byte);
            wr_en = ({1'b0, k} < STORE_USED);
          end else if (16'(k) == len_r) begin
            u_rcrc = rx_byte;
          end
        end
      endcase
      if (!frame_end) begin
        if (cnt >= MAX_CNT) begin
          ovf_nxt = 1'b1;
        end else begin
          pos_nxt = pos_r + PW'(1);
        end
      end
    end

    crc_nxt  = u_crc;
    type_nxt = u_type;
    len_nxt  = u_len;
    rcrc_nxt = u_rcrc;
    sok_nxt  = u_sok;

    if (acc && frame_end) begin
      if (!ovf_r && cnt < MIN_CNT) begin
        st = ST_SHORT;
      end else if (!u_sok) begin
        st = ST_BAD_SOF;
      end else if (rx_byte != EOF_BYTE) begin
        st = ST_BAD_EOF;
      end else if (ovf_r) begin
        st = ST_TOO_LONG;
      end else if (17'(cnt) != 17'(u_len) + 17'(MIN_FRAME)) begin
        st = ST_LENGTH;
      end else if (u_rcrc != u_crc) begin
        st = ST_CRC;
      end else if (u_type != cfg_notify_r && u_type != cfg_realtime_r &&
                   u_type != cfg_status_r) begin
        st = ST_TYPE;
      end
      done.valid  = 1'b1;
      done.run    = (st == ST_OK) && (u_len != 16'd0);
      done.status = st;
      done.ftype  = u_type;
      done.flen   = u_len;
      // The next byte starts a new frame.
      pos_nxt  = '0;
      ovf_nxt  = 1'b0;
      crc_nxt  = 8'd0;
      type_nxt = 8'd0;
      len_nxt  = 16'd0;
      rcrc_nxt = 8'd0;
      sok_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      crc_r  <= 8'd0;
      type_r <= 8'd0;
      len_r  <= 16'd0;
      rcrc_r <= 8'd0;
      sok_r  <= 1'b0;
      ovf_r  <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      crc_r  <= crc_nxt;
      type_r <= type_nxt;
      len_r  <= len_nxt;
      rcrc_r <= rcrc_nxt;
      sok_r  <= sok_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_notify_r   <= 8'd1;
      cfg_realtime_r <= 8'd2;
      cfg_status_r   <= 8'd3;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_TYPE_NOTIFY:   cfg_notify_r   <= cfg_data;
        REG_TYPE_REALTIME: cfg_realtime_r <= cfg_data;
        REG_TYPE_STATUS:   cfg_status_r   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/fcc_replay.sv
module fcc_replay import fcc_pkg::*; #(
  parameter int AW = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  fcc_done_t     done,
  input  logic [7:0]    rd_q,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  output logic          rp_active,
  output logic [AW-1:0] rp_ptr,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    out_status,
  output logic [7:0]    out_type,
  output logic [15:0]   out_len,
  output logic [7:0]    out_byte,
  output logic          out_has,
  output logic          out_last
);

  logic          act_r, act_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [7:0]    rtype_r, rtype_nxt;
  logic [15:0]   rlen_r, rlen_nxt;
  logic          ov_r, ov_nxt;
  status_t       ost_r, ost_nxt;
  logic [7:0]    otype_r, otype_nxt;
  logic [15:0]   olen_r, olen_nxt;
  logic          ohas_r, ohas_nxt;
  logic          olast_r, olast_nxt;
  logic          slot_free, issue, at_last;

  // The output register is refilled on the same edge at which it empties.
  assign slot_free = !ov_r || out_ready;
  assign issue     = act_r && slot_free;
  assign at_last   = (16'(ptr_r) == rlen_r - 16'd1);
  assign rd_en     = issue;
  assign rd_addr   = ptr_r;
  assign rp_active = act_r;
  assign rp_ptr    = ptr_r;

  always_comb begin
    act_nxt   = act_r;
    ptr_nxt   = ptr_r;
    rtype_nxt = rtype_r;
    rlen_nxt  = rlen_r;
    ov_nxt    = ov_r;
    ost_nxt   = ost_r;
    otype_nxt = otype_r;
    olen_nxt  = olen_r;
    ohas_nxt  = ohas_r;
    olast_nxt = olast_r;
    if (done.valid && done.run) begin
      act_nxt   = 1'b1;
      ptr_nxt   = '0;
      rtype_nxt = done.ftype;
      rlen_nxt  = done.flen;
      if (out_ready) begin
        ov_nxt = 1'b0;
      end
    end else if (done.valid) begin
      ov_nxt    = 1'b1;
      ost_nxt   = done.status;
      otype_nxt = done.ftype;
      olen_nxt  = done.flen;
      ohas_nxt  = 1'b0;
      olast_nxt = 1'b1;
    end else if (issue) begin
      ov_nxt    = 1'b1;
      ost_nxt   = ST_OK;
      otype_nxt = rtype_r;
      olen_nxt  = rlen_r;
      ohas_nxt  = 1'b1;
      olast_nxt = at_last;
      ptr_nxt   = ptr_r + AW'(1);
      if (at_last) begin
        act_nxt = 1'b0;
      end
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      act_r <= act_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r   <= ptr_nxt;
    rtype_r <= rtype_nxt;
    rlen_r  <= rlen_nxt;
    ost_r   <= ost_nxt;
    otype_r <= otype_nxt;
    olen_r  <= olen_nxt;
    ohas_r  <= ohas_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid  = ov_r;
  assign out_status = ost_r;
  assign out_type   = otype_r;
  assign out_len    = olen_r;
  assign out_byte   = ohas_r ? rd_q : 8'd0;
  assign out_has    = ohas_r;
  assign out_last   = olast_r;

endmodule
